FILE: src/msc_pkg.sv
// Shared types, codes and fixed-point constants of the mass-spring chain core.
// No dependencies; every other file of the core imports this package.
package msc_pkg;

	// Field widths of the item, result and configuration beats
	localparam int CMD_W     = 2;
	localparam int TILT_W    = 16;
	localparam int POS_W     = 32;
	localparam int ROW_W     = 4;
	localparam int CFG_W     = 32;
	localparam int CFG_IDX_W = 2;
	localparam int BF_W      = 23;
	localparam int RG_W      = 19;
	localparam int DT_W      = 24;

	// Internal widths
	localparam int DRIVE_W   = 26;
	localparam int FRIC_W    = 15;
	localparam int VMIN_W    = 18;
	localparam int K_W       = 28;
	localparam int FORCE_W   = 36;

	// Item commands
	typedef enum logic [CMD_W-1:0] {
		CMD_TICK     = 2'd0,
		CMD_RESTART  = 2'd1,
		CMD_SET_LEAD = 2'd2,
		CMD_END_AUTO = 2'd3
	} cmd_t;

	// Configuration register indexes
	typedef enum logic [CFG_IDX_W-1:0] {
		REG_BUTTON_FORCE   = 2'd0,
		REG_RESTORE_GAIN   = 2'd1,
		REG_RESTORE_CENTRE = 2'd2,
		REG_TIME_STEP      = 2'd3
	} reg_idx_t;

	// Register reset values
	localparam logic [BF_W-1:0]         BF_RESET     = 23'd1966080;
	localparam logic [RG_W-1:0]         RG_RESET     = 19'd65536;
	localparam logic signed [POS_W-1:0] CENTRE_RESET = 32'sd0;
	localparam logic [DT_W-1:0]         DT_RESET     = 24'd55924;

	// Physics constants: spring 6000, tilt gain 0.7, friction 0.05 / 0.25,
	// friction times ten for the dead band
	localparam logic signed [13:0]        SPRING_K       = 14'sd6000;
	localparam logic signed [17:0]        TILT_GAIN      = 18'sd45875;
	localparam logic [FRIC_W-1:0]         FRIC_LOW       = 15'd3277;
	localparam logic [FRIC_W-1:0]         FRIC_HIGH      = 15'd16384;
	localparam logic [17:0]               FRIC_LOW_X10   = 18'd32770;
	localparam logic [17:0]               FRIC_HIGH_X10  = 18'd163840;
	localparam logic signed [DRIVE_W-1:0] DRIVE_LIMIT    = 26'sd1638400;
	localparam logic signed [DRIVE_W-1:0] DRIVE_LIMIT_N  = -26'sd1638400;
	localparam logic signed [FORCE_W-1:0] FORCE_MAX      = {1'b0, {(FORCE_W-1){1'b1}}};
	localparam logic signed [FORCE_W-1:0] FORCE_MIN      = {1'b1, {(FORCE_W-1){1'b0}}};

	// Commands from the sequencer to the datapath, one strobe per step
	typedef struct packed {
		logic latch;
		logic restart;
		logic set_lead;
		logic end_auto;
		logic pre;
		logic ld0;
		logic v_rd;
		logic v_ld;
		logic v_m1;
		logic v_sum;
		logic v_m2;
		logic v_acc;
		logic v_wr;
		logic p_rd;
		logic p_mul;
		logic p_add;
	} msc_ctl_t;

	// Status from the datapath to the sequencer
	typedef struct packed {
		logic last_row;
		logic out_free;
	} msc_sts_t;

endpackage

FILE: src/msc_if.sv
// Handshake channels of the mass-spring chain core: item in, result out.
// Depends on msc_pkg for field widths.
interface msc_item_if;
	import msc_pkg::*;

	logic                      valid;
	logic                      ready;
	logic [CMD_W-1:0]          command;
	logic signed [TILT_W-1:0]  tilt;
	logic                      button_left;
	logic                      button_right;
	logic                      button_brake;
	logic signed [POS_W-1:0]   lead_position;

	modport source (
		output valid, command, tilt, button_left, button_right, button_brake,
		       lead_position,
		input  ready
	);
	modport sink (
		input  valid, command, tilt, button_left, button_right, button_brake,
		       lead_position,
		output ready
	);
endinterface

interface msc_result_if;
	import msc_pkg::*;

	logic                     valid;
	logic                     ready;
	logic [ROW_W-1:0]         row;
	logic signed [POS_W-1:0]  position;
	logic                     auto_active;
	logic                     last;

	modport source (
		output valid, row, position, auto_active, last,
		input  ready
	);
	modport sink (
		input  valid, row, position, auto_active, last,
		output ready
	);
endinterface

FILE: src/msc_ctrl.sv
// Sequencer of the mass-spring chain core: decodes commands and walks each tick
// through the velocity pass and the position pass. Depends on msc_pkg.
module msc_ctrl (
	input  logic                    clk,
	input  logic                    arst_n,
	input  logic                    item_valid,
	input  logic [msc_pkg::CMD_W-1:0] item_command,
	output logic                    item_ready,
	input  msc_pkg::msc_sts_t       sts,
	output msc_pkg::msc_ctl_t       ctl
);
	import msc_pkg::*;

	typedef enum logic [12:0] {
		S_IDLE = 13'b0000000000001,
		S_PRE  = 13'b0000000000010,
		S_LD0  = 13'b0000000000100,
		S_VRD  = 13'b0000000001000,
		S_VLD  = 13'b0000000010000,
		S_VM1  = 13'b0000000100000,
		S_VSUM = 13'b0000001000000,
		S_VM2  = 13'b0000010000000,
		S_VACC = 13'b0000100000000,
		S_VWR  = 13'b0001000000000,
		S_PRD  = 13'b0010000000000,
		S_PMUL = 13'b0100000000000,
		S_PADD = 13'b1000000000000
	} state_t;

	state_t state_q;
	state_t state_d;
	logic   take;

	assign item_ready = (state_q == S_IDLE);
	assign take       = item_valid & item_ready;

	// Next state and step strobes
	always_comb begin
		ctl     = '0;
		state_d = state_q;
		case (state_q)
			S_IDLE: begin
				if (take) begin
					case (item_command)
						CMD_TICK: begin
							ctl.latch = 1'b1;
							state_d   = S_PRE;
						end
						CMD_RESTART:  ctl.restart  = 1'b1;
						CMD_SET_LEAD: ctl.set_lead = 1'b1;
						CMD_END_AUTO: ctl.end_auto = 1'b1;
						default: ;
					endcase
				end
			end
			S_PRE: begin
				ctl.pre = 1'b1;
				state_d = S_LD0;
			end
			S_LD0: begin
				ctl.ld0 = 1'b1;
				state_d = S_VRD;
			end
			S_VRD: begin
				ctl.v_rd = 1'b1;
				state_d  = S_VLD;
			end
			S_VLD: begin
				ctl.v_ld = 1'b1;
				state_d  = S_VM1;
			end
			S_VM1: begin
				ctl.v_m1 = 1'b1;
				state_d  = S_VSUM;
			end
			S_VSUM: begin
				ctl.v_sum = 1'b1;
				state_d   = S_VM2;
			end
			S_VM2: begin
				ctl.v_m2 = 1'b1;
				state_d  = S_VACC;
			end
			S_VACC: begin
				ctl.v_acc = 1'b1;
				state_d   = S_VWR;
			end
			S_VWR: begin
				ctl.v_wr = 1'b1;
				state_d  = sts.last_row ? S_PRD : S_VRD;
			end
			S_PRD: begin
				ctl.p_rd = 1'b1;
				state_d  = S_PMUL;
			end
			S_PMUL: begin
				ctl.p_mul = 1'b1;
				state_d   = S_PADD;
			end
			S_PADD: begin
				// hold until the result register can take the beat
				if (sts.out_free) begin
					ctl.p_add = 1'b1;
					state_d   = sts.last_row ? S_IDLE : S_PRD;
				end
			end
			default: state_d = S_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

endmodule

FILE: src/msc_datapath.sv
// Datapath of the mass-spring chain core: row stores, configuration registers,
// force and integration arithmetic, result register. Depends on msc_pkg.
module msc_datapath #(
	parameter int ROWS = 16
) (
	input  logic                             clk,
	input  logic                             arst_n,
	input  msc_pkg::msc_ctl_t                ctl,
	output msc_pkg::msc_sts_t                sts,
	input  logic                             cfg_we,
	input  logic [msc_pkg::CFG_IDX_W-1:0]    cfg_index,
	input  logic [msc_pkg::CFG_W-1:0]        cfg_data,
	input  logic signed [msc_pkg::TILT_W-1:0] tilt,
	input  logic                             button_left,
	input  logic                             button_right,
	input  logic                             button_brake,
	input  logic signed [msc_pkg::POS_W-1:0] lead_position,
	output logic                             res_valid,
	input  logic                             res_ready,
	output logic [msc_pkg::ROW_W-1:0]        res_row,
	output logic signed [msc_pkg::POS_W-1:0] res_position,
	output logic                             res_auto_active,
	output logic                             res_last
);
	import msc_pkg::*;

	localparam int IW     = $clog2(ROWS);
	localparam int SP_W   = 47;
	localparam int REST_W = 53;
	localparam int SUM_W  = 49;
	localparam int WIDE_W = 41;
	localparam int PV_W   = 57;
	localparam logic [IW-1:0] LAST_IDX = IW'(ROWS - 1);
	localparam logic signed [POS_W-1:0] POS_MAX = {1'b0, {(POS_W-1){1'b1}}};
	localparam logic signed [POS_W-1:0] POS_MIN = {1'b1, {(POS_W-1){1'b0}}};

	function automatic logic signed [POS_W-1:0] sat_word(input logic signed [WIDE_W-1:0] x);
		if (x > WIDE_W'(POS_MAX)) begin
			return POS_MAX;
		end else if (x < WIDE_W'(POS_MIN)) begin
			return POS_MIN;
		end
		return x[POS_W-1:0];
	endfunction

	// Configuration registers
	logic [BF_W-1:0]         bf_q;
	logic [RG_W-1:0]         rg_q;
	logic signed [POS_W-1:0] centre_q;
	logic [DT_W-1:0]         dt_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			bf_q     <= BF_RESET;
			rg_q     <= RG_RESET;
			centre_q <= CENTRE_RESET;
			dt_q     <= DT_RESET;
		end else if (cfg_we) begin
			case (cfg_index)
				REG_BUTTON_FORCE:   bf_q     <= cfg_data[BF_W-1:0];
				REG_RESTORE_GAIN:   rg_q     <= cfg_data[RG_W-1:0];
				REG_RESTORE_CENTRE: centre_q <= $signed(cfg_data[POS_W-1:0]);
				REG_TIME_STEP:      dt_q     <= cfg_data[DT_W-1:0];
				default: ;
			endcase
		end
	end

	// Row counter
	logic [IW-1:0] cnt_q;
	logic          last_row;
	logic [IW-1:0] next_idx;

	assign last_row = (cnt_q == LAST_IDX);
	assign next_idx = last_row ? cnt_q : cnt_q + IW'(1);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= '0;
		end else if (ctl.latch) begin
			cnt_q <= '0;
		end else if (ctl.v_wr || ctl.p_add) begin
			cnt_q <= last_row ? '0 : cnt_q + IW'(1);
		end
	end

	// Latch the tick's inputs
	logic signed [TILT_W-1:0] tilt_q;
	logic                     left_q;
	logic                     right_q;
	logic                     brake_q;

	always_ff @(posedge clk) begin
		if (ctl.latch) begin
			tilt_q  <= tilt;
			left_q  <= button_left;
			right_q <= button_right;
			brake_q <= button_brake;
		end
	end

	// Per-tick terms: lead drive, friction, dead band and 10*dt
	logic signed [32:0]        tilt_prod;
	logic signed [24:0]        btn_term;
	logic signed [DRIVE_W-1:0] drive_d;
	logic [17:0]               fric10;
	logic [41:0]               vmin_prod;
	logic [K_W-1:0]            k_d;
	logic signed [DRIVE_W-1:0] drive_q;
	logic [VMIN_W-1:0]         vmin_q;
	logic [FRIC_W-1:0]         fric_q;
	logic [K_W-1:0]            k_q;
	logic                      drive_over;

	assign tilt_prod = 33'(tilt_q) * 33'(TILT_GAIN);

	always_comb begin
		if (right_q && !left_q) begin
			btn_term = $signed({2'b00, bf_q});
		end else if (left_q && !right_q) begin
			btn_term = -$signed({2'b00, bf_q});
		end else begin
			btn_term = '0;
		end
	end

	assign drive_d    = DRIVE_W'($signed(tilt_prod[32:8])) + DRIVE_W'(btn_term);
	assign fric10     = brake_q ? FRIC_HIGH_X10 : FRIC_LOW_X10;
	assign vmin_prod  = 42'(fric10) * 42'(dt_q);
	assign k_d        = (K_W'(dt_q) << 3) + (K_W'(dt_q) << 1);
	assign drive_over = (drive_q > DRIVE_LIMIT) || (drive_q < DRIVE_LIMIT_N);

	always_ff @(posedge clk) begin
		if (ctl.pre) begin
			drive_q <= drive_d;
			vmin_q  <= vmin_prod[41:24];
			fric_q  <= brake_q ? FRIC_HIGH : FRIC_LOW;
			k_q     <= k_d;
		end
	end

	// Auto mode: a drive beyond the limit ends it before row 0 is handled
	logic auto_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			auto_q <= 1'b1;
		end else if (ctl.restart) begin
			auto_q <= 1'b1;
		end else if (ctl.end_auto) begin
			auto_q <= 1'b0;
		end else if (ctl.ld0 && drive_over) begin
			auto_q <= 1'b0;
		end
	end

	// Position store: one write and one registered read per cycle
	logic signed [POS_W-1:0] pos_mem [ROWS];
	logic [ROWS-1:0]         pos_vld_q;
	logic                    pos_rd_en;
	logic [IW-1:0]           pos_rd_addr;
	logic                    pos_we;
	logic [IW-1:0]           pos_wr_addr;
	logic signed [POS_W-1:0] pos_wr_data;
	logic signed [POS_W-1:0] pos_rd_q;
	logic                    pos_rdv_q;
	logic signed [POS_W-1:0] pos_rd;
	logic signed [POS_W-1:0] pos_new;

	assign pos_rd_en   = ctl.pre | ctl.v_rd | ctl.p_rd;
	assign pos_we      = ctl.set_lead | ctl.p_add;
	assign pos_wr_addr = ctl.p_add ? cnt_q : '0;
	assign pos_wr_data = ctl.p_add ? pos_new : lead_position;
	assign pos_rd      = pos_rdv_q ? pos_rd_q : '0;

	always_comb begin
		if (ctl.v_rd) begin
			pos_rd_addr = next_idx;
		end else if (ctl.p_rd) begin
			pos_rd_addr = cnt_q;
		end else begin
			pos_rd_addr = '0;
		end
	end

	always_ff @(posedge clk) begin
		if (pos_we) begin
			pos_mem[pos_wr_addr] <= pos_wr_data;
		end
		if (pos_rd_en) begin
			pos_rd_q <= pos_mem[pos_rd_addr];
		end
	end

	// Unwritten rows read as zero
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pos_vld_q <= '0;
			pos_rdv_q <= 1'b0;
		end else begin
			if (ctl.restart) begin
				pos_vld_q <= '0;
			end else if (pos_we) begin
				pos_vld_q[pos_wr_addr] <= 1'b1;
			end
			if (pos_rd_en) begin
				pos_rdv_q <= pos_vld_q[pos_rd_addr];
			end
		end
	end

	// Velocity store; row 0 keeps its velocity while auto mode is on
	logic signed [POS_W-1:0] vel_mem [ROWS];
	logic [ROWS-1:0]         vel_vld_q;
	logic                    vel_rd_en;
	logic                    vel_we;
	logic signed [POS_W-1:0] vel_rd_q;
	logic                    vel_rdv_q;
	logic signed [POS_W-1:0] vel_rd;
	logic signed [POS_W-1:0] vel_new;

	assign vel_rd_en = ctl.v_rd | ctl.p_rd;
	assign vel_we    = ctl.v_wr && !((cnt_q == '0) && auto_q);
	assign vel_rd    = vel_rdv_q ? vel_rd_q : '0;

	always_ff @(posedge clk) begin
		if (vel_we) begin
			vel_mem[cnt_q] <= vel_new;
		end
		if (vel_rd_en) begin
			vel_rd_q <= vel_mem[cnt_q];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vel_vld_q <= '0;
			vel_rdv_q <= 1'b0;
		end else begin
			if (ctl.restart) begin
				vel_vld_q <= '0;
			end else if (vel_we) begin
				vel_vld_q[cnt_q] <= 1'b1;
			end
			if (vel_rd_en) begin
				vel_rdv_q <= vel_vld_q[cnt_q];
			end
		end
	end

	// Position window around the current row; the centre slot also holds
	// the old position during the position pass
	logic signed [POS_W-1:0] win_prev_q;
	logic signed [POS_W-1:0] win_cur_q;
	logic signed [POS_W-1:0] win_next_q;
	logic signed [POS_W-1:0] vel_cur_q;

	always_ff @(posedge clk) begin
		if (ctl.ld0) begin
			win_next_q <= pos_rd;
		end else if (ctl.v_ld) begin
			win_prev_q <= win_cur_q;
			win_cur_q  <= win_next_q;
			win_next_q <= pos_rd;
			vel_cur_q  <= vel_rd;
		end else if (ctl.p_mul) begin
			win_cur_q  <= pos_rd;
		end
	end

	// Spring, restore and friction terms
	logic signed [32:0]       d_l;
	logic signed [32:0]       d_r;
	logic signed [32:0]       d_c;
	logic signed [32:0]       vmin_s;
	logic signed [32:0]       vel_s;
	logic signed [FRIC_W:0]   fterm_d;
	logic signed [SP_W-1:0]   sp_l_q;
	logic signed [SP_W-1:0]   sp_r_q;
	logic signed [REST_W-1:0] rest_q;
	logic signed [FRIC_W:0]   fterm_q;

	assign d_l    = 33'(win_prev_q) - 33'(win_cur_q);
	assign d_r    = 33'(win_next_q) - 33'(win_cur_q);
	assign d_c    = 33'(centre_q) - 33'(win_cur_q);
	assign vmin_s = $signed({15'b0, vmin_q});
	assign vel_s  = 33'(vel_cur_q);

	// Friction acts against the velocity only outside the dead band
	always_comb begin
		if (vel_s > vmin_s) begin
			fterm_d = -$signed({1'b0, fric_q});
		end else if (vel_s < -vmin_s) begin
			fterm_d = $signed({1'b0, fric_q});
		end else begin
			fterm_d = '0;
		end
	end

	always_ff @(posedge clk) begin
		if (ctl.v_m1) begin
			sp_l_q  <= SP_W'(d_l) * SP_W'(SPRING_K);
			sp_r_q  <= SP_W'(d_r) * SP_W'(SPRING_K);
			rest_q  <= REST_W'(d_c) * REST_W'($signed({1'b0, rg_q}));
			fterm_q <= fterm_d;
		end
	end

	// Sum the row's force and saturate it
	logic signed [SUM_W-1:0]   f_base;
	logic signed [SUM_W-1:0]   f_right;
	logic signed [SUM_W-1:0]   f_sum;
	logic signed [FORCE_W-1:0] f_sat;
	logic signed [FORCE_W-1:0] force_q;

	assign f_base  = (cnt_q == '0) ? SUM_W'(drive_q) : SUM_W'(sp_l_q);
	assign f_right = last_row ? '0 : SUM_W'(sp_r_q);
	assign f_sum   = f_base + f_right + SUM_W'($signed(rest_q[REST_W-1:16])) + SUM_W'(fterm_q);

	always_comb begin
		if (f_sum > SUM_W'(FORCE_MAX)) begin
			f_sat = FORCE_MAX;
		end else if (f_sum < SUM_W'(FORCE_MIN)) begin
			f_sat = FORCE_MIN;
		end else begin
			f_sat = f_sum[FORCE_W-1:0];
		end
	end

	always_ff @(posedge clk) begin
		if (ctl.v_sum) begin
			force_q <= f_sat;
		end
	end

	// force * 10 * dt as two partial products over the force halves
	logic [17:0]         f_lo;
	logic signed [17:0]  f_hi;
	logic [45:0]         p_lo_q;
	logic signed [46:0]  p_hi_q;
	logic [63:0]         p_total;
	logic signed [39:0]  dv_q;
	logic signed [WIDE_W-1:0] vel_sum;

	assign f_lo    = force_q[17:0];
	assign f_hi    = $signed(force_q[FORCE_W-1:18]);
	assign p_total = (64'(p_hi_q) << 18) + 64'(p_lo_q);
	assign vel_sum = WIDE_W'(vel_cur_q) + WIDE_W'(dv_q);
	assign vel_new = sat_word(vel_sum);

	always_ff @(posedge clk) begin
		if (ctl.v_m2) begin
			p_lo_q <= 46'(f_lo) * 46'(k_q);
			p_hi_q <= 47'(f_hi) * 47'($signed({1'b0, k_q}));
		end
		if (ctl.v_acc) begin
			dv_q <= $signed(p_total[63:24]);
		end
	end

	// Advance the position by velocity * dt
	logic signed [PV_W-1:0]   pv_q;
	logic signed [WIDE_W-1:0] pos_sum;

	assign pos_sum = WIDE_W'(win_cur_q) + WIDE_W'($signed(pv_q[PV_W-1:24]));
	assign pos_new = sat_word(pos_sum);

	always_ff @(posedge clk) begin
		if (ctl.p_mul) begin
			pv_q <= PV_W'(vel_rd) * PV_W'($signed({1'b0, dt_q}));
		end
	end

	// Result register
	logic                    res_valid_q;
	logic [ROW_W-1:0]        res_row_q;
	logic signed [POS_W-1:0] res_pos_q;
	logic                    res_auto_q;
	logic                    res_last_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_valid_q <= 1'b0;
		end else if (ctl.p_add) begin
			res_valid_q <= 1'b1;
		end else if (res_ready) begin
			res_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (ctl.p_add) begin
			res_row_q  <= ROW_W'(cnt_q);
			res_pos_q  <= pos_new;
			res_auto_q <= auto_q;
			res_last_q <= last_row;
		end
	end

	assign res_valid       = res_valid_q;
	assign res_row         = res_row_q;
	assign res_position    = res_pos_q;
	assign res_auto_active = res_auto_q;
	assign res_last        = res_last_q;

	assign sts.last_row = last_row;
	assign sts.out_free = !res_valid_q || res_ready;

endmodule

FILE: src/mass_spring_chain_step_core.sv
// Top level of the mass-spring chain core: sequencer plus datapath.
// Depends on msc_pkg, msc_if, msc_ctrl and msc_datapath.
//
//   channel  dir  beat                                             accepted
//   item     in   command, tilt, buttons, lead_position            valid & ready
//   result   out  row, position, auto_active, last                 valid & ready
//   cfg      in   cfg_index, cfg_data (4 registers)                cfg_we
//
// A tick runs a pre step and a row-0 load, then takes each row through the shared
// force and velocity path, then each row through the position update, each row
// store having one read port. Items wait out a tick; other commands stay in idle.
// Reset leaves all rows at zero and auto mode on; no clearing pass is needed.
// A stalled result beat holds the position pass; the item side stays ready once idle.
module mass_spring_chain_step_core #(
	parameter int ROWS = 16
) (
	input  logic                          clk,
	input  logic                          arst_n,
	msc_item_if.sink                      item,
	msc_result_if.source                  result,
	input  logic                          cfg_we,
	input  logic [msc_pkg::CFG_IDX_W-1:0] cfg_index,
	input  logic [msc_pkg::CFG_W-1:0]     cfg_data
);
	import msc_pkg::*;

	msc_ctl_t ctl;
	msc_sts_t sts;
	logic     item_ready;

	assign item.ready = item_ready;

	msc_ctrl u_ctrl (
		.clk          (clk),
		.arst_n       (arst_n),
		.item_valid   (item.valid),
		.item_command (item.command),
		.item_ready   (item_ready),
		.sts          (sts),
		.ctl          (ctl)
	);

	msc_datapath #(
		.ROWS (ROWS)
	) u_datapath (
		.clk             (clk),
		.arst_n          (arst_n),
		.ctl             (ctl),
		.sts             (sts),
		.cfg_we          (cfg_we),
		.cfg_index       (cfg_index),
		.cfg_data        (cfg_data),
		.tilt            (item.tilt),
		.button_left     (item.button_left),
		.button_right    (item.button_right),
		.button_brake    (item.button_brake),
		.lead_position   (item.lead_position),
		.res_valid       (result.valid),
		.res_ready       (result.ready),
		.res_row         (result.row),
		.res_position    (result.position),
		.res_auto_active (result.auto_active),
		.res_last        (result.last)
	);

endmodule
